### hdl/glk_pkg.sv
package glk_pkg;

    // Defaults for the top-level parameters
    localparam int FRAC_BITS_DEF  = 12;
    localparam int COORD_BITS_DEF = 18;

    // Field widths fixed by the item format
    localparam int OFF_W   = 11;
    localparam int DIM_W   = 10;
    localparam int ADV_W   = 11;
    localparam int KERN_W  = 9;
    localparam int EXT_W   = 17;
    localparam int SCALE_W = 16;
    localparam int BASE_W  = 12;
    localparam int PEN_W   = 32;

    // Input beat payload width (six fields, padded to whole bytes)
    localparam int IN_DATA_W = 64;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE    = 2'd0,
        CFG_KERN_EN  = 2'd1,
        CFG_BASELINE = 2'd2
    } t_cfg_idx;

    // Intermediate widths
    localparam int YS_W   = 14;                    // off_y + height - baseline
    localparam int KP_W   = KERN_W + SCALE_W + 1;  // kern * scale
    localparam int AP_W   = ADV_W + SCALE_W + 1;   // advance * scale
    localparam int XP0_W  = OFF_W + SCALE_W + 1;   // off_x * scale
    localparam int XP1_W  = OFF_W + SCALE_W + 2;   // (off_x + width) * scale
    localparam int YP_W   = YS_W + SCALE_W + 1;    // vertical terms * scale
    localparam int BLS_W  = BASE_W + SCALE_W;      // baseline * scale
    localparam int SBF_W  = BLS_W + 1;             // rounded scaled baseline, fixed point
    localparam int VX_W   = PEN_W + 1;             // unrounded coordinate sums
    localparam int VY_W   = PEN_W;
    localparam int RND_W  = VX_W + 2;              // rounded coordinates with headroom

    typedef struct packed {
        logic                     first;
        logic signed [OFF_W-1:0]  off_x;
        logic signed [OFF_W-1:0]  off_y;
        logic [DIM_W-1:0]         glyph_width;
        logic [DIM_W-1:0]         glyph_height;
        logic signed [ADV_W-1:0]  advance;
        logic signed [KERN_W-1:0] kern;
    } t_item;

    // Per-item control flags carried down the pipe
    typedef struct packed {
        logic first;
        logic wnz;
        logic hnz;
    } t_flag;

    typedef struct packed {
        t_flag              flag;
        logic [KP_W-1:0]    pk;
        logic [AP_W-1:0]    pa;
        logic [XP0_W-1:0]   px0;
        logic [XP1_W-1:0]   px1;
        logic [YP_W-1:0]    py0;
        logic [YP_W-1:0]    py1;
    } t_prod;

    typedef struct packed {
        t_flag              flag;
        logic [PEN_W-1:0]   pen_k;
        logic [XP0_W-1:0]   px0;
        logic [XP1_W-1:0]   px1;
        logic [YP_W-1:0]    py0;
        logic [YP_W-1:0]    py1;
    } t_pen;

    typedef struct packed {
        t_flag             flag;
        logic [VX_W-1:0]   vx0;
        logic [VX_W-1:0]   vx1;
        logic [VY_W-1:0]   vy0;
        logic [VY_W-1:0]   vy1;
    } t_sum;

    typedef struct packed {
        t_flag             flag;
        logic [RND_W-1:0]  x0;
        logic [RND_W-1:0]  x1;
        logic [RND_W-1:0]  y0;
        logic [RND_W-1:0]  y1;
    } t_rnd;

endpackage

### hdl/glyph_layout_scaled_kerned.sv
// Glyph layout with font scaling and pair kerning.
//
// Input stream (s_axis): one beat per glyph with its offsets, size, advance
// and the pair kerning; tuser marks the first glyph of a string, which
// restarts the pen and the running extent. Output stream (m_axis): one beat
// per glyph with the scaled destination rectangle, the string extent so far,
// and in tuser a flag that is low when the scale is zero.
// Configuration (scale, kerning enable, baseline) goes through the plain write
// port; the user must do so only while the block is empty (not enforced).
//
// Seven register stages: input, scale products, pen accumulator, edge sums,
// rounding, growth and clipping, output. One glyph is taken and one result
// given per cycle while m_axis_tready is high; the pen accumulator closes
// its loop through its single pen register. Reset empties every stage, clears
// the pen and extent and loads scale 4096 (1.0 at the default FRAC_BITS),
// kerning on and baseline 0. When m_axis stalls, empty stages still take
// beats; s_axis_tready falls only once all seven stages hold a glyph.
module glyph_layout_scaled_kerned #(
    parameter  int FRAC_BITS  = glk_pkg::FRAC_BITS_DEF,
    parameter  int COORD_BITS = glk_pkg::COORD_BITS_DEF,
    localparam int OUT_DATA_W = ((4 * COORD_BITS + 2 * glk_pkg::EXT_W + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [glk_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [glk_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // Glyph input
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // off_x, off_y, glyph_width, glyph_height, advance, kern (from bit 0)
    input  logic [glk_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // first
    input  logic                              s_axis_tuser,
    // Rectangle output
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // left, top, right, bottom, extent_right, extent_bottom (from bit 0)
    output logic [OUT_DATA_W-1:0]             m_axis_tdata,
    // valid_res
    output logic                              m_axis_tuser
);

    localparam int NSTG = 7;

    logic [glk_pkg::SCALE_W-1:0]    r_scale;
    logic                           r_kern_en;
    logic [glk_pkg::BASE_W-1:0]     r_baseline;
    logic                           r_v_in;
    glk_pkg::t_item                 r_item;
    glk_pkg::t_item                 w_item;
    glk_pkg::t_prod                 w_prod;
    glk_pkg::t_sum                  w_sum;
    glk_pkg::t_flag                 w_flag;
    logic [NSTG:1]                  w_v;
    logic [NSTG:1]                  w_en;
    logic signed [COORD_BITS-1:0]   w_x0;
    logic signed [COORD_BITS-1:0]   w_x1;
    logic signed [COORD_BITS-1:0]   w_y0;
    logic signed [COORD_BITS-1:0]   w_y1;
    logic [COORD_BITS-1:0]          w_left;
    logic [COORD_BITS-1:0]          w_top;
    logic [COORD_BITS-1:0]          w_right;
    logic [COORD_BITS-1:0]          w_bottom;
    logic [glk_pkg::EXT_W-1:0]      w_ext_r;
    logic [glk_pkg::EXT_W-1:0]      w_ext_b;
    logic                           w_vres;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale    <= glk_pkg::SCALE_RESET;
            r_kern_en  <= 1'b1;
            r_baseline <= '0;
        end else if (i_cfg_we) begin
            unique case (glk_pkg::t_cfg_idx'(i_cfg_addr))
                glk_pkg::CFG_SCALE:    r_scale    <= i_cfg_wdata;
                glk_pkg::CFG_KERN_EN:  r_kern_en  <= i_cfg_wdata[0];
                glk_pkg::CFG_BASELINE: r_baseline <= i_cfg_wdata[glk_pkg::BASE_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage advance: a stage loads when it is empty or its successor moves on
    always_comb begin
        w_en[NSTG] = !w_v[NSTG] || m_axis_tready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            w_en[k] = !w_v[k] || w_en[k+1];
        end
    end

    assign s_axis_tready = w_en[1];

    // Unpack the input beat
    always_comb begin
        w_item.first        = s_axis_tuser;
        w_item.off_x        = s_axis_tdata[10:0];
        w_item.off_y        = s_axis_tdata[21:11];
        w_item.glyph_width  = s_axis_tdata[31:22];
        w_item.glyph_height = s_axis_tdata[41:32];
        w_item.advance      = s_axis_tdata[52:42];
        w_item.kern         = s_axis_tdata[61:53];
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in <= 1'b0;
        end else if (w_en[1]) begin
            r_v_in <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_item <= w_item;
        end
    end

    assign w_v[1] = r_v_in;

    glk_mul u_mul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en[2]),
        .i_valid    (w_v[1]),
        .i_item     (r_item),
        .i_scale    (r_scale),
        .i_kern_en  (r_kern_en),
        .i_baseline (r_baseline),
        .o_valid    (w_v[2]),
        .o_prod     (w_prod)
    );

    glk_pen #(
        .FRAC_BITS (FRAC_BITS)
    ) u_pen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en_pen    (w_en[3]),
        .i_en_sum    (w_en[4]),
        .i_valid     (w_v[2]),
        .i_prod      (w_prod),
        .i_scale     (r_scale),
        .i_baseline  (r_baseline),
        .o_pen_valid (w_v[3]),
        .o_valid     (w_v[4]),
        .o_sum       (w_sum)
    );

    glk_round #(
        .FRAC_BITS  (FRAC_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_round (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en_rnd    (w_en[5]),
        .i_en_sat    (w_en[6]),
        .i_valid     (w_v[4]),
        .i_sum       (w_sum),
        .o_rnd_valid (w_v[5]),
        .o_valid     (w_v[6]),
        .o_flag      (w_flag),
        .o_x0        (w_x0),
        .o_x1        (w_x1),
        .o_y0        (w_y0),
        .o_y1        (w_y1)
    );

    glk_ext #(
        .COORD_BITS (COORD_BITS)
    ) u_ext (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en[7]),
        .i_valid      (w_v[6]),
        .i_flag       (w_flag),
        .i_x0         (w_x0),
        .i_x1         (w_x1),
        .i_y0         (w_y0),
        .i_y1         (w_y1),
        .i_scale_zero (r_scale == '0),
        .o_valid      (w_v[7]),
        .o_left       (w_left),
        .o_top        (w_top),
        .o_right      (w_right),
        .o_bottom     (w_bottom),
        .o_ext_right  (w_ext_r),
        .o_ext_bottom (w_ext_b),
        .o_valid_res  (w_vres)
    );

    // Output beat
    assign m_axis_tvalid = w_v[NSTG];
    assign m_axis_tuser  = w_vres;
    assign m_axis_tdata  = OUT_DATA_W'({w_ext_b, w_ext_r, w_bottom, w_right, w_top, w_left});

    // An empty output register never holds off the input side
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");

    // Input is held off only when every stage holds a glyph
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (&w_v))
        else $error("input stalled with a bubble in the pipe");

    // Zero scale gives an all-zero rectangle
    a_zero_scale_rect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            (w_left == '0) && (w_top == '0) && (w_right == '0) && (w_bottom == '0))
        else $error("rectangle not cleared for zero scale");

    // Rectangles are never inverted
    a_rect_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            ($signed(w_right) >= $signed(w_left)) && ($signed(w_bottom) >= $signed(w_top)))
        else $error("inverted destination rectangle");

endmodule

### hdl/glk_mul.sv
module glk_mul (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  glk_pkg::t_item                     i_item,
    input  logic [glk_pkg::SCALE_W-1:0]        i_scale,
    input  logic                               i_kern_en,
    input  logic [glk_pkg::BASE_W-1:0]         i_baseline,
    output logic                               o_valid,
    output glk_pkg::t_prod                     o_prod
);

    logic                                  r_valid;
    glk_pkg::t_prod                        r_prod;
    glk_pkg::t_prod                        n_prod;

    logic signed [glk_pkg::SCALE_W:0]      w_scale_s;
    logic signed [glk_pkg::KERN_W-1:0]     w_kern;
    logic signed [glk_pkg::OFF_W:0]        w_ox_w;
    logic signed [glk_pkg::YS_W-1:0]       w_oy_bl;
    logic signed [glk_pkg::YS_W-1:0]       w_oy_h_bl;

    // Narrow pre-adds ahead of the multipliers
    assign w_scale_s = $signed({1'b0, i_scale});
    assign w_kern    = i_kern_en ? i_item.kern : '0;
    assign w_ox_w    = $signed({i_item.off_x[glk_pkg::OFF_W-1], i_item.off_x})
                     + $signed({2'b00, i_item.glyph_width});
    assign w_oy_bl   = glk_pkg::YS_W'(i_item.off_y) - $signed({2'b00, i_baseline});
    assign w_oy_h_bl = w_oy_bl + $signed({4'b0000, i_item.glyph_height});

    // Six independent scale products
    always_comb begin
        n_prod.flag.first = i_item.first;
        n_prod.flag.wnz   = |i_item.glyph_width;
        n_prod.flag.hnz   = |i_item.glyph_height;
        n_prod.pk  = glk_pkg::KP_W'(w_kern) * glk_pkg::KP_W'(w_scale_s);
        n_prod.pa  = glk_pkg::AP_W'(i_item.advance) * glk_pkg::AP_W'(w_scale_s);
        n_prod.px0 = glk_pkg::XP0_W'(i_item.off_x) * glk_pkg::XP0_W'(w_scale_s);
        n_prod.px1 = glk_pkg::XP1_W'(w_ox_w) * glk_pkg::XP1_W'(w_scale_s);
        n_prod.py0 = glk_pkg::YP_W'(w_oy_bl) * glk_pkg::YP_W'(w_scale_s);
        n_prod.py1 = glk_pkg::YP_W'(w_oy_h_bl) * glk_pkg::YP_W'(w_scale_s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule

### hdl/glk_pen.sv
module glk_pen #(
    parameter int FRAC_BITS = glk_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en_pen,
    input  logic                           i_en_sum,
    input  logic                           i_valid,
    input  glk_pkg::t_prod                 i_prod,
    input  logic [glk_pkg::SCALE_W-1:0]    i_scale,
    input  logic [glk_pkg::BASE_W-1:0]     i_baseline,
    output logic                           o_pen_valid,
    output logic                           o_valid,
    output glk_pkg::t_sum                  o_sum
);

    localparam int SBF_W = glk_pkg::SBF_W;
    localparam logic [SBF_W-1:0] HALF_U    = SBF_W'(2 ** (FRAC_BITS - 1));
    localparam logic [SBF_W-1:0] FRAC_MASK = SBF_W'((2 ** FRAC_BITS) - 1);

    logic [glk_pkg::PEN_W-1:0]   r_pen;
    logic [glk_pkg::BLS_W-1:0]   r_bls;
    logic [SBF_W-1:0]            r_sbf;
    logic                        r_v_pen;
    logic                        r_v_sum;
    glk_pkg::t_pen               r_s_pen;
    glk_pkg::t_pen               n_s_pen;
    glk_pkg::t_sum               r_s_sum;
    glk_pkg::t_sum               n_s_sum;
    logic [glk_pkg::PEN_W-1:0]   w_base;
    logic [glk_pkg::PEN_W-1:0]   n_pen;

    // Scaled baseline, rounded to whole pixels; follows config continuously
    always_ff @(posedge i_clk) begin
        r_bls <= glk_pkg::BLS_W'(i_baseline) * glk_pkg::BLS_W'(i_scale);
        r_sbf <= (SBF_W'(r_bls) + HALF_U) & ~FRAC_MASK;
    end

    // Pen accumulator: kerned pen for this glyph, then advance
    always_comb begin
        w_base = i_prod.flag.first ? '0 : r_pen;
        n_s_pen.flag  = i_prod.flag;
        n_s_pen.pen_k = w_base + glk_pkg::PEN_W'($signed(i_prod.pk));
        n_s_pen.px0   = i_prod.px0;
        n_s_pen.px1   = i_prod.px1;
        n_s_pen.py0   = i_prod.py0;
        n_s_pen.py1   = i_prod.py1;
        n_pen         = n_s_pen.pen_k + glk_pkg::PEN_W'($signed(i_prod.pa));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen   <= '0;
            r_v_pen <= 1'b0;
        end else if (i_en_pen) begin
            r_v_pen <= i_valid;
            if (i_valid) begin
                r_pen <= n_pen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_pen) begin
            r_s_pen <= n_s_pen;
        end
    end

    // Edge positions in fixed point, before rounding
    always_comb begin
        n_s_sum.flag = r_s_pen.flag;
        n_s_sum.vx0  = glk_pkg::VX_W'($signed(r_s_pen.pen_k))
                     + glk_pkg::VX_W'($signed(r_s_pen.px0));
        n_s_sum.vx1  = glk_pkg::VX_W'($signed(r_s_pen.pen_k))
                     + glk_pkg::VX_W'($signed(r_s_pen.px1));
        n_s_sum.vy0  = glk_pkg::VY_W'($signed({1'b0, r_sbf}))
                     + glk_pkg::VY_W'($signed(r_s_pen.py0));
        n_s_sum.vy1  = glk_pkg::VY_W'($signed({1'b0, r_sbf}))
                     + glk_pkg::VY_W'($signed(r_s_pen.py1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_sum <= 1'b0;
        end else if (i_en_sum) begin
            r_v_sum <= r_v_pen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            r_s_sum <= n_s_sum;
        end
    end

    assign o_pen_valid = r_v_pen;
    assign o_valid     = r_v_sum;
    assign o_sum       = r_s_sum;

endmodule

### hdl/glk_round.sv
module glk_round #(
    parameter int FRAC_BITS  = glk_pkg::FRAC_BITS_DEF,
    parameter int COORD_BITS = glk_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en_rnd,
    input  logic                          i_en_sat,
    input  logic                          i_valid,
    input  glk_pkg::t_sum                 i_sum,
    output logic                          o_rnd_valid,
    output logic                          o_valid,
    output glk_pkg::t_flag                o_flag,
    output logic signed [COORD_BITS-1:0]  o_x0,
    output logic signed [COORD_BITS-1:0]  o_x1,
    output logic signed [COORD_BITS-1:0]  o_y0,
    output logic signed [COORD_BITS-1:0]  o_y1
);

    localparam int RND_W = glk_pkg::RND_W;
    localparam int VX_W  = glk_pkg::VX_W;
    localparam logic signed [RND_W-1:0] HALF    = RND_W'(2 ** (FRAC_BITS - 1));
    localparam logic signed [RND_W-1:0] HALF_M1 = RND_W'((2 ** (FRAC_BITS - 1)) - 1);
    localparam logic signed [RND_W-1:0] ONE     = RND_W'(1);
    localparam logic signed [RND_W-1:0] C_MAX   = RND_W'((2 ** (COORD_BITS - 1)) - 1);
    localparam logic signed [RND_W-1:0] C_MIN   = RND_W'(-(2 ** (COORD_BITS - 1)));
    localparam logic signed [COORD_BITS-1:0] C_MAX_O = COORD_BITS'((2 ** (COORD_BITS - 1)) - 1);
    localparam logic signed [COORD_BITS-1:0] C_MIN_O = COORD_BITS'(-(2 ** (COORD_BITS - 1)));

    // Round half away from zero: negative values take half minus one, then floor
    function automatic logic signed [RND_W-1:0] fx_round(input logic [VX_W-1:0] v);
        logic signed [RND_W-1:0] t;
        t = RND_W'($signed(v)) + (v[VX_W-1] ? HALF_M1 : HALF);
        return t >>> FRAC_BITS;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] sat_c(input logic signed [RND_W-1:0] v);
        logic signed [COORD_BITS-1:0] r;
        if (v > C_MAX) begin
            r = C_MAX_O;
        end else if (v < C_MIN) begin
            r = C_MIN_O;
        end else begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

    logic                           r_v_rnd;
    logic                           r_v_sat;
    glk_pkg::t_rnd                  r_s_rnd;
    glk_pkg::t_rnd                  n_s_rnd;
    glk_pkg::t_flag                 r_flag;
    logic signed [COORD_BITS-1:0]   r_x0;
    logic signed [COORD_BITS-1:0]   r_x1;
    logic signed [COORD_BITS-1:0]   r_y0;
    logic signed [COORD_BITS-1:0]   r_y1;
    logic signed [RND_W-1:0]        w_x0;
    logic signed [RND_W-1:0]        w_x1;
    logic signed [RND_W-1:0]        w_y0;
    logic signed [RND_W-1:0]        w_y1;
    logic signed [RND_W-1:0]        w_x1a;
    logic signed [RND_W-1:0]        w_y0a;

    // Round the left, right, top and bottom edges to whole pixels
    always_comb begin
        n_s_rnd.flag = i_sum.flag;
        n_s_rnd.x0   = fx_round(i_sum.vx0);
        n_s_rnd.x1   = fx_round(i_sum.vx1);
        n_s_rnd.y0   = fx_round(VX_W'($signed(i_sum.vy0)));
        n_s_rnd.y1   = fx_round(VX_W'($signed(i_sum.vy1)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_rnd <= 1'b0;
        end else if (i_en_rnd) begin
            r_v_rnd <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_rnd) begin
            r_s_rnd <= n_s_rnd;
        end
    end

    // Grow rectangles that rounding made empty, then clip to coordinate range
    assign w_x0  = $signed(r_s_rnd.x0);
    assign w_x1  = $signed(r_s_rnd.x1);
    assign w_y0  = $signed(r_s_rnd.y0);
    assign w_y1  = $signed(r_s_rnd.y1);
    assign w_x1a = (w_x0 >= w_x1 && r_s_rnd.flag.wnz) ? w_x1 + ONE : w_x1;
    assign w_y0a = (w_y0 >= w_y1) ? (r_s_rnd.flag.hnz ? w_y1 - ONE : w_y1) : w_y0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_sat <= 1'b0;
        end else if (i_en_sat) begin
            r_v_sat <= r_v_rnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_sat) begin
            r_flag <= r_s_rnd.flag;
            r_x0   <= sat_c(w_x0);
            r_x1   <= sat_c(w_x1a);
            r_y0   <= sat_c(w_y0a);
            r_y1   <= sat_c(w_y1);
        end
    end

    assign o_rnd_valid = r_v_rnd;
    assign o_valid     = r_v_sat;
    assign o_flag      = r_flag;
    assign o_x0        = r_x0;
    assign o_x1        = r_x1;
    assign o_y0        = r_y0;
    assign o_y1        = r_y1;

endmodule

### hdl/glk_ext.sv
module glk_ext #(
    parameter int COORD_BITS = glk_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  glk_pkg::t_flag                i_flag,
    input  logic signed [COORD_BITS-1:0]  i_x0,
    input  logic signed [COORD_BITS-1:0]  i_x1,
    input  logic signed [COORD_BITS-1:0]  i_y0,
    input  logic signed [COORD_BITS-1:0]  i_y1,
    input  logic                          i_scale_zero,
    output logic                          o_valid,
    output logic [COORD_BITS-1:0]         o_left,
    output logic [COORD_BITS-1:0]         o_top,
    output logic [COORD_BITS-1:0]         o_right,
    output logic [COORD_BITS-1:0]         o_bottom,
    output logic [glk_pkg::EXT_W-1:0]     o_ext_right,
    output logic [glk_pkg::EXT_W-1:0]     o_ext_bottom,
    output logic                          o_valid_res
);

    localparam int E_W = COORD_BITS - 1;

    logic                    r_valid;
    logic [E_W-1:0]          r_max_r;
    logic [E_W-1:0]          r_max_b;
    logic [COORD_BITS-1:0]   r_left;
    logic [COORD_BITS-1:0]   r_top;
    logic [COORD_BITS-1:0]   r_right;
    logic [COORD_BITS-1:0]   r_bottom;
    logic                    r_vres;
    logic [E_W-1:0]          w_e_r;
    logic [E_W-1:0]          w_e_b;
    logic [E_W-1:0]          w_base_r;
    logic [E_W-1:0]          w_base_b;
    logic                    w_area;
    logic [E_W-1:0]          n_max_r;
    logic [E_W-1:0]          n_max_b;

    // Running extent of glyphs with area; a first glyph restarts it
    assign w_e_r    = i_x1[COORD_BITS-1] ? '0 : i_x1[E_W-1:0];
    assign w_e_b    = i_y1[COORD_BITS-1] ? '0 : i_y1[E_W-1:0];
    assign w_base_r = i_flag.first ? '0 : r_max_r;
    assign w_base_b = i_flag.first ? '0 : r_max_b;
    assign w_area   = i_flag.wnz && i_flag.hnz;
    assign n_max_r  = (w_area && w_e_r > w_base_r) ? w_e_r : w_base_r;
    assign n_max_b  = (w_area && w_e_b > w_base_b) ? w_e_b : w_base_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_max_r <= '0;
            r_max_b <= '0;
        end else if (i_en) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_max_r <= n_max_r;
                r_max_b <= n_max_b;
            end
        end
    end

    // Output register; rectangle reads as zero when the scale is zero
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_left   <= i_scale_zero ? '0 : i_x0;
            r_top    <= i_scale_zero ? '0 : i_y0;
            r_right  <= i_scale_zero ? '0 : i_x1;
            r_bottom <= i_scale_zero ? '0 : i_y1;
            r_vres   <= !i_scale_zero;
        end
    end

    assign o_valid      = r_valid;
    assign o_left       = r_left;
    assign o_top        = r_top;
    assign o_right      = r_right;
    assign o_bottom     = r_bottom;
    assign o_ext_right  = glk_pkg::EXT_W'(r_max_r);
    assign o_ext_bottom = glk_pkg::EXT_W'(r_max_b);
    assign o_valid_res  = r_vres;

endmodule
